@@ hw/rtl/isq_pkg.sv @@
// Shared constants, codes and types for the integer stack with queries.
// No dependencies; compile first.
`default_nettype none

package isq_pkg;

    // Store geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 5;
    localparam int FAULT_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd2;

    // Start value of the maximum scan
    localparam logic signed [DATA_W-1:0] LARGEST_INIT = -32'sd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } isq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/isq_cmd_if.sv @@
// Command channel: valid/ready handshake carrying mode and value.
// Depends on isq_pkg.
`default_nettype none

interface isq_cmd_if
    import isq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/isq_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one query result.
// Depends on isq_pkg.
`default_nettype none

interface isq_rsp_if
    import isq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic                     is_empty;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [DATA_W-1:0] largest;
    logic [COUNT_W-1:0]       key_count;
    logic                     key_found;
    logic [FAULT_W-1:0]       fault;

    modport source (output valid, output top_value, output is_empty, output entry_count,
                    output largest, output key_count, output key_found, output fault,
                    input ready);
    modport sink   (input valid, input top_value, input is_empty, input entry_count,
                    input largest, input key_count, input key_found, input fault,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/isq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/integer_stack_with_queries.sv @@
// Integer stack with queries: LIFO of signed 32-bit entries with max/count scan.
// Depends on isq_pkg, isq_cmd_if, isq_rsp_if and isq_ram.
// Sequence: after accept the entries are scanned (ST_SCAN), the last read returns
//   (ST_DRAIN) and the response loads in ST_DONE; an empty stack skips the scan.
//   A command is taken only in idle. The single RAM read port walks the entries
//   one per cycle; the done state waits while a stalled receiver holds a response.
// Reset: rst_n (async, active low) empties the stack and idles the sequencer;
//   store contents are not cleared, entries are only read after being written.
`default_nettype none

module integer_stack_with_queries
    import isq_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    isq_cmd_if.sink   cmd,
    isq_rsp_if.source rsp
);

    // ------------------------------------------------------------------
    // Sequencer and bookkeeping state
    // ------------------------------------------------------------------
    isq_state_t state_reg, state_next;

    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [FAULT_W-1:0]       fault_reg, fault_next;
    logic signed [DATA_W-1:0] key_reg;

    // Scan pipeline: address issue, then compare on returned data
    logic [ADDR_W-1:0]        rd_idx_reg;
    logic                     pend_reg;
    logic [ADDR_W-1:0]        pend_idx_reg;
    logic [ADDR_W-1:0]        last_idx;

    // Accumulators
    logic signed [DATA_W-1:0] largest_reg;
    logic [CNT_W-1:0]         match_reg;
    logic signed [DATA_W-1:0] top_reg;

    // Response register
    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] rsp_top_reg;
    logic                     rsp_empty_reg;
    logic [COUNT_W-1:0]       rsp_count_reg;
    logic signed [DATA_W-1:0] rsp_largest_reg;
    logic [COUNT_W-1:0]       rsp_key_count_reg;
    logic                     rsp_found_reg;
    logic [FAULT_W-1:0]       rsp_fault_reg;

    // Control strobes
    logic              accept;
    logic              ram_we;
    logic              rd_en;
    logic              load_out;
    logic [DATA_W-1:0] ram_rdata;

    assign accept   = cmd.valid && cmd.ready;
    assign last_idx = ADDR_W'(fill_reg - 1'b1);

    // ------------------------------------------------------------------
    // Stack update on accept: push writes at the fill level, pop drops
    // the top by lowering the fill level; full or empty faults hold.
    // ------------------------------------------------------------------
    always_comb
    begin
        fill_next  = fill_reg;
        fault_next = fault_reg;
        ram_we     = 1'b0;
        if (accept)
        begin
            fault_next = FAULT_NONE;
            unique case (cmd.mode)
                MODE_PUSH:
                begin
                    if (fill_reg == CNT_W'(DEPTH))
                    begin
                        fault_next = FAULT_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                MODE_POP:
                begin
                    if (fill_reg == '0)
                    begin
                        fault_next = FAULT_EMPTY;
                    end
                    else
                    begin
                        fill_next = fill_reg - 1'b1;
                    end
                end
                default:
                begin
                    // query only, unused code acts as query
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // an empty stack needs no scan
                    state_next = (fill_next == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd.ready = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  cmd.ready = 1'b1;
            ST_SCAN:  rd_en     = 1'b1;
            ST_DRAIN: rd_en     = 1'b0;
            ST_DONE:  load_out  = !rsp_valid_reg || rsp.ready;
            default:  cmd.ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Entry store
    // ------------------------------------------------------------------
    isq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(fill_reg)),
        .wdata (cmd.value),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= rd_en;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan datapath: one entry per cycle through the shared compare unit
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        fault_reg    <= fault_next;
        pend_idx_reg <= rd_idx_reg;
        if (accept)
        begin
            key_reg     <= cmd.value;
            rd_idx_reg  <= '0;
            largest_reg <= LARGEST_INIT;
            match_reg   <= '0;
            top_reg     <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (pend_reg)
            begin
                if ($signed(ram_rdata) > largest_reg)
                begin
                    largest_reg <= $signed(ram_rdata);
                end
                if ($signed(ram_rdata) == key_reg)
                begin
                    match_reg <= match_reg + 1'b1;
                end
                // the last entry scanned is the top of the stack
                if (pend_idx_reg == last_idx)
                begin
                    top_reg <= $signed(ram_rdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response register: hold until taken, counts masked to field width
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_top_reg       <= top_reg;
            rsp_empty_reg     <= (fill_reg == '0);
            rsp_count_reg     <= COUNT_W'(fill_reg);
            rsp_largest_reg   <= largest_reg;
            rsp_key_count_reg <= COUNT_W'(match_reg);
            rsp_found_reg     <= (match_reg != '0);
            rsp_fault_reg     <= fault_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.top_value   = rsp_top_reg;
    assign rsp.is_empty    = rsp_empty_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.largest     = rsp_largest_reg;
    assign rsp.key_count   = rsp_key_count_reg;
    assign rsp.key_found   = rsp_found_reg;
    assign rsp.fault       = rsp_fault_reg;

endmodule

`default_nettype wire

@@ verif/stack_result_checker.sv @@
// Result checker for the integer stack with queries: predicts each result and compares it.
// Depends on isq_pkg, isq_cmd_if and isq_rsp_if; instantiated by integer_stack_with_queries_tb.

module stack_result_checker
    import isq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    isq_cmd_if        cmd,
    isq_rsp_if        rsp,
    output int        fail_count,
    output int        pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [DATA_W-1:0] top_value;
        logic                     is_empty;
        logic [COUNT_W-1:0]       entry_count;
        logic signed [DATA_W-1:0] largest;
        logic [COUNT_W-1:0]       key_count;
        logic                     key_found;
        logic [FAULT_W-1:0]       fault;
    } stack_view_t;

    // Shadow copy of the stack contents
    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int unsigned              shadow_fill;

    stack_view_t expected_views [$];
    int          mismatches;
    int          results_seen;

    // Apply one operation to the shadow stack and return the view after it.
    function automatic stack_view_t apply_operation(input logic [MODE_W-1:0] op,
                                                    input logic signed [DATA_W-1:0] key);
        stack_view_t view;
        int unsigned key_hits;
        view.fault = FAULT_NONE;
        if (op == MODE_PUSH) begin
            if (shadow_fill >= DEPTH)
                view.fault = FAULT_FULL;
            else begin
                shadow_entries[shadow_fill] = key;
                shadow_fill++;
            end
        end
        else if (op == MODE_POP) begin
            if (shadow_fill == 0)
                view.fault = FAULT_EMPTY;
            else
                shadow_fill--;
        end
        view.top_value = (shadow_fill > 0) ? shadow_entries[shadow_fill - 1] : '0;
        view.largest   = LARGEST_INIT;
        key_hits       = 0;
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_entries[i] > view.largest)
                view.largest = shadow_entries[i];
            if (shadow_entries[i] == key)
                key_hits++;
        end
        view.is_empty    = (shadow_fill == 0);
        view.entry_count = COUNT_W'(shadow_fill);
        view.key_count   = COUNT_W'(key_hits);
        view.key_found   = (key_hits != 0);
        return view;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (mismatches < REPORT_LIMIT)
            $display("%0t %m: result %0d: %s", $realtime, results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            log_failure($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    always @(posedge clk or negedge rst_n) begin
        stack_view_t want;
        if (!rst_n) begin
            shadow_fill = 0;
            expected_views.delete();
            fail_count   = 0;
            mismatches   = 0;
            results_seen = 0;
        end
        else begin
            if (cmd.valid && cmd.ready)
                expected_views.push_back(apply_operation(cmd.mode, cmd.value));
            if (rsp.valid && rsp.ready) begin
                if (expected_views.size() == 0)
                    log_failure("unexpected result, no item outstanding");
                else begin
                    want = expected_views.pop_front();
                    check_field("top_value",   want.top_value,   rsp.top_value);
                    check_field("is_empty",    want.is_empty,    rsp.is_empty);
                    check_field("entry_count", want.entry_count, rsp.entry_count);
                    check_field("largest",     want.largest,     rsp.largest);
                    check_field("key_count",   want.key_count,   rsp.key_count);
                    check_field("key_found",   want.key_found,   rsp.key_found);
                    check_field("fault",       want.fault,       rsp.fault);
                end
                results_seen++;
            end
        end
        pending_results = expected_views.size();
    end

endmodule

@@ verif/integer_stack_with_queries_tb.sv @@
// Top of the integer stack with queries testbench: clock, reset, stimulus and verdict.
// Depends on isq_pkg, isq_cmd_if, isq_rsp_if, the block and stack_result_checker.

module integer_stack_with_queries_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isq_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int KEY_POOL_SIZE   = 8;
    // Cycles without any handshake before the run is declared hung. The slowest
    // legal gap is a full-store scan plus long random stalls on both sides.
    localparam int IDLE_LIMIT      = 5000;
    // Tail after the last result: a little over two full-store item times.
    localparam int DRAIN_CYCLES    = 2 * (DEPTH + 3) + 4;

    // Mode 3 has no name in the package; the block treats it as a query.
    localparam logic [MODE_W-1:0]        MODE_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] DATA_MIN    = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] DATA_MAX    = 32'sh7FFF_FFFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    isq_cmd_if cmd_ch ();
    isq_rsp_if rsp_ch ();

    // Percent chance per cycle that the sender holds off / the receiver stalls
    int cmd_idle_pct  = 0;
    int rsp_stall_pct = 0;

    int fail_total;
    int pending_results;
    int quiet_cycles = 0;

    // Random operation mix alternates between stretches that mostly grow the
    // stack and stretches that mostly shrink it, so full and empty are both hit.
    bit filling  = 1'b0;
    int run_left = 0;

    // Small set of recurring keys so that duplicate entries and matches occur
    logic signed [DATA_W-1:0] key_pool [KEY_POOL_SIZE];

    always #(CLK_PERIOD / 2) clk = ~clk;

    integer_stack_with_queries dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    stack_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_total),
        .pending_results (pending_results)
    );

    // Receiver: one fresh ready decision per cycle, held low during reset.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Watchdog: end the run when no item moves on either channel for too long.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[integer_stack_with_queries] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one item and hold it until the block takes it. An optional hold-off
    // comes first; valid only drops when a hold-off actually happens, so a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic send_item(input logic [MODE_W-1:0] op,
                             input logic signed [DATA_W-1:0] data);
        if (cmd_idle_pct != 0 && $urandom_range(99) < cmd_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < cmd_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= op;
        cmd_ch.value <= data;
        // ready is sampled before the edge's updates land, so this is race free
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // Draw a key: mostly recurring pool values, some extremes, rest fully random.
    function automatic logic signed [DATA_W-1:0] pick_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        if (pick < 60) begin
            case ($urandom_range(3))
                0:       return DATA_MIN;
                1:       return DATA_MAX;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_random_item();
        int                  pick;
        logic [MODE_W-1:0]   op;
        if (run_left == 0) begin
            filling  = !filling;
            run_left = $urandom_range(50, 20);
        end
        run_left--;
        pick = $urandom_range(99);
        if (filling)
            op = (pick < 65) ? MODE_PUSH : (pick < 80) ? MODE_POP :
                 (pick < 95) ? MODE_QUERY : MODE_UNUSED;
        else
            op = (pick < 65) ? MODE_POP : (pick < 80) ? MODE_PUSH :
                 (pick < 95) ? MODE_QUERY : MODE_UNUSED;
        send_item(op, pick_key());
    endtask

    initial begin
        // Known values on every block input from time zero
        cmd_ch.valid = 1'b0;
        cmd_ch.mode  = MODE_QUERY;
        cmd_ch.value = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = (i < 4) ? DATA_W'(i) - 1 : $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-stack answers, pop while empty, the unused mode,
        // extreme values, duplicates, a minimum entry that stays below the
        // -1 floor of the maximum, and alternating bit patterns.
        send_item(MODE_QUERY,  '0);
        send_item(MODE_POP,    32'sd5);
        send_item(MODE_UNUSED, -32'sd1);
        send_item(MODE_PUSH,   DATA_MIN);
        send_item(MODE_QUERY,  DATA_MIN);
        send_item(MODE_PUSH,   -32'sd1);
        send_item(MODE_PUSH,   DATA_MAX);
        send_item(MODE_PUSH,   '0);
        send_item(MODE_PUSH,   DATA_MAX);
        send_item(MODE_QUERY,  DATA_MAX);
        send_item(MODE_UNUSED, '0);
        send_item(MODE_POP,    -32'sd1);
        send_item(MODE_POP,    '0);
        send_item(MODE_QUERY,  -32'sd1);
        send_item(MODE_POP,    DATA_MIN);
        send_item(MODE_POP,    DATA_MAX);
        send_item(MODE_POP,    '0);
        send_item(MODE_POP,    '0);
        send_item(MODE_PUSH,   32'sh5555_5555);
        send_item(MODE_PUSH,   32'shAAAA_AAAA);
        send_item(MODE_QUERY,  32'shAAAA_AAAA);
        send_item(MODE_POP,    32'sh5555_5555);
        send_item(MODE_POP,    '0);

        // Random: four pacing phases, stack contents carry across phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin cmd_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin cmd_idle_pct = 88; rsp_stall_pct = 0;  end
                2:       begin cmd_idle_pct = 0;  rsp_stall_pct = 88; end
                default: begin cmd_idle_pct = 36; rsp_stall_pct = 36; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
        cmd_ch.valid <= 1'b0;

        // Drain: wait for every outstanding result, then a short tail so any
        // stray extra result still gets caught.
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_total == 0 && pending_results == 0)
            $display("[integer_stack_with_queries] OK");
        else
            $display("[integer_stack_with_queries] ERROR");
        $finish;
    end

endmodule
